/* hdl/fadr_pkg.sv */
// Shared constants, types and start table for the flow-average drive regulator.
`timescale 1ns / 1ps

package fadr_pkg;

    // Window, alarm and drive sizing
    localparam int AVG_WINDOW  = 3000;
    localparam int ALARM_TICKS = 5000;
    localparam int DRIVE_BITS  = 12;

    // Field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int SET_W     = 6;
    localparam int AVG_W     = 8;
    localparam int WIN_W     = 12;
    localparam int ZERO_W    = 13;
    localparam int SUM_W     = 28;
    localparam int FRAC_BITS = 8;
    localparam int SHI_W     = SUM_W - FRAC_BITS;

    // Drive tuning widths: error against the target, stepped drive
    localparam int DIFF_W = AVG_W + 2;
    localparam int DRV_W  = DRIVE_BITS + 2;

    localparam logic [DRIVE_BITS-1:0] DRIVE_RESET = DRIVE_BITS'(1800);
    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX   = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX     = '1;
    localparam logic [SET_W-1:0]      SET_RESET   = SET_W'(5);
    localparam logic [AVG_W-1:0]      AVG_MAX     = '1;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Division of the window sum by the window length: reciprocal multiply
    localparam int              RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_VAL   = (64'd1 << RECIP_SHIFT) / AVG_WINDOW;
    localparam int              RECIP_W     = $clog2(RECIP_VAL + 1);
    localparam int              PROD_W      = SHI_W + RECIP_W;
    localparam int              QUO_W       = $clog2(((2 ** SHI_W) - 1) / AVG_WINDOW + 1);
    localparam int              QX_W        = (QUO_W > AVG_W) ? QUO_W + 1 : AVG_W + 1;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);

    // Command queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Start table, indexed by set flow from TABLE_LO to TABLE_HI
    localparam int TABLE_LO = 5;
    localparam int TABLE_HI = 60;
    localparam int TABLE_N  = TABLE_HI - TABLE_LO + 1;

    localparam int START_TABLE [TABLE_N] = '{
        1850, 1860, 1870, 1880, 1890, 1900, 1905, 1910, 1915, 1920,
        1920, 1925, 1925, 1925, 1925, 1930, 1935, 1940, 1945, 1950,
        1955, 1955, 1955, 1955, 1955, 1960, 1965, 1970, 1975, 1980,
        1985, 1985, 1985, 1985, 1985, 2000, 2005, 2010, 2015, 2020,
        2025, 2025, 2025, 2025, 2025, 2030, 2035, 2040, 2045, 2050,
        2055, 2055, 2055, 2055, 2055, 2060
    };

    typedef enum logic [1:0] {
        OP_START,
        OP_TICK,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             alarm;
        logic [SHI_W-1:0] sum_hi;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Start drive for a set flow, index clamped to the table range
    function automatic logic [DRIVE_BITS-1:0] start_drive(input logic [SET_W-1:0] sf);
        logic [SET_W-1:0] idx;
        idx = sf;
        if (sf < SET_W'(TABLE_LO)) begin
            idx = SET_W'(TABLE_LO);
        end else if (sf > SET_W'(TABLE_HI)) begin
            idx = SET_W'(TABLE_HI);
        end
        return DRIVE_BITS'(START_TABLE[idx - SET_W'(TABLE_LO)]);
    endfunction

endpackage

/* hdl/fadr_front.sv */
// Front end: accepts words, keeps the window, zero-flow and sum counters, issues commands.
`timescale 1ns / 1ps

module fadr_front import fadr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [SAMPLE_W-1:0] s_flow_sample,
    input  q_status_t           q_status,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic [WIN_W-1:0]  window_count_reg, window_count_next;
    logic [ZERO_W-1:0] zero_count_reg, zero_count_next;
    logic [SUM_W-1:0]  flow_sum_reg, flow_sum_next;

    logic              accept;
    logic              sample_zero;
    logic              alarm;
    logic              close;
    logic [ZERO_W-1:0] zero_inc;
    logic [WIN_W-1:0]  win_base;
    logic [WIN_W-1:0]  win_inc;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;

    // Accept whenever the queue has room
    assign s_ready = !q_status.full;
    assign accept  = s_valid && !q_status.full;
    assign q_push  = accept;

    // Classify the tick: zero-flow alarm, window close, saturated sum
    always_comb begin
        sample_zero = (s_flow_sample == '0);
        zero_inc    = zero_count_reg + 1'b1;
        alarm       = sample_zero && (zero_inc >= ZERO_W'(ALARM_TICKS));
        win_base    = alarm ? '0 : window_count_reg;
        win_inc     = win_base + 1'b1;
        close       = (win_inc >= WIN_W'(AVG_WINDOW));
        sum_wide    = {1'b0, flow_sum_reg} + (SUM_W + 1)'(s_flow_sample);
        sum_sat     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    // Build the command for the back end
    always_comb begin
        q_cmd.sum_hi = sum_sat[SUM_W-1:FRAC_BITS];
        if (s_action == ACT_START) begin
            q_cmd.op    = OP_START;
            q_cmd.alarm = 1'b0;
        end else begin
            q_cmd.op    = close ? OP_CLOSE : OP_TICK;
            q_cmd.alarm = alarm;
        end
    end

    // Advance the counters on an accepted word
    always_comb begin
        window_count_next = window_count_reg;
        zero_count_next   = zero_count_reg;
        flow_sum_next     = flow_sum_reg;
        if (accept) begin
            if (s_action == ACT_START) begin
                window_count_next = '0;
            end else begin
                if (sample_zero) begin
                    zero_count_next = alarm ? '0 : zero_inc;
                end
                window_count_next = close ? '0 : win_inc;
                flow_sum_next     = close ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_count_reg <= '0;
            zero_count_reg   <= '0;
            flow_sum_reg     <= '0;
        end else begin
            window_count_reg <= window_count_next;
            zero_count_reg   <= zero_count_next;
            flow_sum_reg     <= flow_sum_next;
        end
    end

endmodule

/* hdl/fadr_queue.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module fadr_queue import fadr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t              fifo_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = fifo_mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/fadr_back.sv */
// Back end: window average by reciprocal multiply, drive tuning and result register.
`timescale 1ns / 1ps

module fadr_back import fadr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [SET_W-1:0]      target_flow,
    input  cmd_t                  q_cmd,
    input  q_status_t             q_status,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DRIVE_BITS-1:0] m_drive_value,
    output logic                  m_supply_alarm,
    output logic                  m_window_done,
    output logic [AVG_W-1:0]      m_flow_average
);

    logic advance;

    // Stage 1: sum times reciprocal
    logic              v1_reg;
    cmd_t              c1_reg;
    logic [PROD_W-1:0] p1_reg;
    logic [SHI_W-1:0]  s1_reg;

    // Stage 2: first quotient and its back product
    logic              v2_reg;
    cmd_t              c2_reg;
    logic [QUO_W-1:0]  q0_reg;
    logic [SHI_W-1:0]  q0w_reg;
    logic [SHI_W-1:0]  s2_reg;
    logic [QUO_W-1:0]  q0;
    logic [SHI_W-1:0]  q0w;

    // Stage 3: corrected, saturated average
    logic              v3_reg;
    cmd_t              c3_reg;
    logic [AVG_W-1:0]  avg3_reg;
    logic [SHI_W-1:0]  rem;
    logic [QX_W-1:0]   qx;
    logic [AVG_W-1:0]  avg;

    // Stage 4: drive state and result
    logic                  out_valid_reg, out_valid_next;
    logic                  alarm_reg, alarm_next;
    logic                  done_reg, done_next;
    logic [DRIVE_BITS-1:0] drive_reg, drive_next;
    logic [AVG_W-1:0]      average_reg, average_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [3:0]        step;
    logic signed [DRV_W-1:0]  drv_wide;
    logic [DRIVE_BITS-1:0]    tuned;

    // Move the whole pipe when the result register is free or being taken
    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && !q_status.empty;

    assign m_valid        = out_valid_reg;
    assign m_drive_value  = drive_reg;
    assign m_supply_alarm = alarm_reg;
    assign m_window_done  = done_reg;
    assign m_flow_average = average_reg;

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= !q_status.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // First quotient is low by at most one
    always_comb begin
        q0  = p1_reg[RECIP_SHIFT +: QUO_W];
        q0w = SHI_W'(SHI_W'(q0) * SHI_W'(AVG_WINDOW));
    end

    // Correct the quotient with the remainder and saturate
    always_comb begin
        rem = s2_reg - q0w_reg;
        qx  = QX_W'(q0_reg) + QX_W'(rem >= SHI_W'(AVG_WINDOW));
        avg = (qx > QX_W'(AVG_MAX)) ? AVG_MAX : qx[AVG_W-1:0];
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            c1_reg   <= q_cmd;
            s1_reg   <= q_cmd.sum_hi;
            p1_reg   <= PROD_W'(q_cmd.sum_hi) * PROD_W'(RECIP);
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            q0_reg   <= q0;
            q0w_reg  <= q0w;
            c3_reg   <= c2_reg;
            avg3_reg <= avg;
        end
    end

    // Step the drive by the error band, clamped to the drive range
    always_comb begin
        diff = $signed(DIFF_W'(avg3_reg) - DIFF_W'(target_flow));
        if (diff >= 4) begin
            step = -4'sd4;
        end else if (diff >= 2) begin
            step = -4'sd2;
        end else if (diff == 1) begin
            step = -4'sd1;
        end else if (diff == 0) begin
            step = 4'sd0;
        end else if (diff == -1) begin
            step = 4'sd1;
        end else if (diff >= -3) begin
            step = 4'sd2;
        end else begin
            step = 4'sd4;
        end
        drv_wide = $signed({2'b00, drive_reg}) + DRV_W'(step);
        if (drv_wide < 0) begin
            tuned = '0;
        end else if (drv_wide > $signed({2'b00, DRIVE_MAX})) begin
            tuned = DRIVE_MAX;
        end else begin
            tuned = drv_wide[DRIVE_BITS-1:0];
        end
    end

    // Carry out the command and load the result register
    always_comb begin
        out_valid_next = out_valid_reg;
        alarm_next     = alarm_reg;
        done_next      = done_reg;
        drive_next     = drive_reg;
        average_next   = average_reg;
        if (advance) begin
            out_valid_next = v3_reg;
            alarm_next     = c3_reg.alarm;
            done_next      = (c3_reg.op == OP_CLOSE);
            if (v3_reg) begin
                case (c3_reg.op)
                    OP_START: begin
                        drive_next = start_drive(target_flow);
                    end
                    OP_CLOSE: begin
                        average_next = avg3_reg;
                        drive_next   = tuned;
                    end
                    OP_TICK: begin
                        drive_next = drive_reg;
                    end
                    default: begin
                        drive_next = drive_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            alarm_reg     <= 1'b0;
            done_reg      <= 1'b0;
            drive_reg     <= DRIVE_RESET;
            average_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            alarm_reg     <= alarm_next;
            done_reg      <= done_next;
            drive_reg     <= drive_next;
            average_reg   <= average_next;
        end
    end

endmodule

/* hdl/flow_average_stepped_dac_regulator.sv */
// An accepted input word passes through the four-word command queue and the
// four-stage back end (reciprocal multiply, quotient correction, drive tuning) to
// its result word on the m_ side; one word per cycle while m_ready does not stall it.
// Reset (aresetn low at a clock edge): set flow 5, drive 1800, counters, sum and
// average cleared, queue and pipeline emptied.
`timescale 1ns / 1ps

module flow_average_stepped_dac_regulator import fadr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [SET_W-1:0]      cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [SAMPLE_W-1:0]   s_flow_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DRIVE_BITS-1:0] m_drive_value,
    output logic                  m_supply_alarm,
    output logic                  m_window_done,
    output logic [AVG_W-1:0]      m_flow_average
);

    logic [SET_W-1:0] target_flow_reg;
    logic             q_push;
    logic             q_pop;
    cmd_t             push_cmd;
    cmd_t             pop_cmd;
    q_status_t        q_status;

    // Set flow register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_flow_reg <= SET_RESET;
        end else if (cfg_wr_en) begin
            target_flow_reg <= cfg_wr_data;
        end
    end

    fadr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_flow_sample (s_flow_sample),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    fadr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    fadr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .target_flow    (target_flow_reg),
        .q_cmd          (pop_cmd),
        .q_status       (q_status),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_value  (m_drive_value),
        .m_supply_alarm (m_supply_alarm),
        .m_window_done  (m_window_done),
        .m_flow_average (m_flow_average)
    );

    // Drive and average state must hold while a result word waits
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_drive_value) && $stable(m_flow_average)))
        else $error("drive or average changed while result word stalled");

    // Queue cannot be full and empty at once
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("command queue reports full and empty");

    // An alarm tick restarts the window, so it cannot also close one
    a_alarm_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_supply_alarm && m_window_done) |-> (AVG_WINDOW == 1))
        else $error("alarm and window close on the same word");

endmodule
